// ----- hdl/crc8fc_pkg.sv -----
// Package for the CRC-8 frame checker: transaction payload types, status codes,
// frame format constants and the byte-wide CRC update function.
// Depends on nothing; every other file of the block but the stream interface imports it.
package crc8fc_pkg;

    localparam int unsigned MAX_FRAME_DEFAULT = 64;

    localparam logic [7:0] HDR_BYTE      = 8'hAA;
    localparam logic [7:0] TAIL_BYTE     = 8'hBB;
    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] LEN_INDEX     = 8'd16;
    localparam logic [7:0] PAYLOAD_START = 8'd17;
    localparam logic [7:0] HDR_LEN       = 8'd2;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_CRC    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        status_t    status;
    } out_item_t;

    // Reflected CRC-8 update over one byte, unrolled bit by bit.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/crc8fc_stream_if.sv -----
// Valid/ready stream interface used for both channels of the frame checker.
// The payload type is a parameter; the types come from crc8fc_pkg.
interface crc8fc_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/crc8fc_core.sv -----
// Frame state of the checker and the single-pass decision logic for one byte.
// Depends on crc8fc_pkg for the item types, constants and CRC function.
module crc8fc_core
    import crc8fc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    output out_item_t result
);

    // Highest allowed end index plus one, kept one bit wider than a byte index.
    localparam logic [8:0] END_LIMIT = 9'(MAX_FRAME - 17);

    logic [7:0] index_reg,  index_next;
    logic [7:0] crc_reg,    crc_next;
    logic [7:0] end_reg,    end_next;
    logic       finished_reg, finished_next;

    logic [7:0] idx;
    logic [7:0] crc_base;
    logic [7:0] end_base;
    logic [7:0] end_latch;
    logic [8:0] len_end;
    logic       active;
    logic       done;
    status_t    st;
    logic       pv;

    // A restart byte is index zero of a fresh frame whatever came before.
    assign active   = item.restart || !finished_reg;
    assign idx      = item.restart ? 8'd0 : index_reg;
    assign crc_base = item.restart ? 8'd0 : crc_reg;
    assign end_base = item.restart ? 8'd0 : end_reg;
    assign len_end  = {1'b0, PAYLOAD_START} + {1'b0, item.rx_byte};

    always_comb
    begin
        done      = 1'b0;
        st        = STATUS_OK;
        pv        = 1'b0;
        end_latch = end_base;
        if (idx < HDR_LEN)
        begin
            if (item.rx_byte != HDR_BYTE)
            begin
                done = 1'b1;
                st   = STATUS_FORMAT;
            end
        end
        else if (idx == LEN_INDEX)
        begin
            if (len_end >= END_LIMIT)
            begin
                done = 1'b1;
                st   = STATUS_FORMAT;
            end
            else
            begin
                end_latch = len_end[7:0];
            end
        end
        else if (idx >= PAYLOAD_START)
        begin
            if (idx < end_base)
            begin
                pv = 1'b1;
            end
            else if ({1'b0, idx} == {1'b0, end_base}
                     || {1'b0, idx} == ({1'b0, end_base} + 9'd1))
            begin
                if (item.rx_byte != TAIL_BYTE)
                begin
                    done = 1'b1;
                    st   = STATUS_FORMAT;
                end
            end
            else
            begin
                done = 1'b1;
                st   = (item.rx_byte == crc_base) ? STATUS_OK : STATUS_CRC;
            end
        end
    end

    always_comb
    begin
        result.payload_byte  = (active && pv) ? item.rx_byte : 8'd0;
        result.payload_valid = active && pv;
        result.frame_done    = active && done;
        result.status        = active ? st : STATUS_OK;
    end

    always_comb
    begin
        index_next    = index_reg;
        crc_next      = crc_reg;
        end_next      = end_reg;
        finished_next = finished_reg;
        if (accept && active)
        begin
            if (done)
            begin
                index_next    = idx;
                crc_next      = crc_base;
                end_next      = end_base;
                finished_next = 1'b1;
            end
            else
            begin
                index_next    = idx + 8'd1;
                crc_next      = crc8_update(crc_base, item.rx_byte);
                end_next      = end_latch;
                finished_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= 8'd0;
            crc_reg      <= 8'd0;
            end_reg      <= 8'd0;
            finished_reg <= 1'b1;
        end
        else
        begin
            index_reg    <= index_next;
            crc_reg      <= crc_next;
            end_reg      <= end_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ----- hdl/crc8fc_out_reg.sv -----
// Result register of the frame checker, driving the result channel.
// Depends on crc8fc_pkg for the result type and on crc8fc_stream_if.
module crc8fc_out_reg
    import crc8fc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      can_load,
    crc8fc_stream_if.source result_ch
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // The register may be refilled in the same cycle its contents are taken.
    assign can_load = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign result_ch.valid   = valid_reg;
    assign result_ch.payload = item_reg;

endmodule

// ----- hdl/crc8_frame_checker.sv -----
// Top level of the CRC-8 frame checker: byte channel in, result channel out.
// Depends on crc8fc_pkg, crc8fc_stream_if, crc8fc_core and crc8fc_out_reg.
//
// The checker takes received frame bytes one transaction at a time and returns
// exactly one result transaction for each. A byte with restart set is index
// zero of a new frame. Bytes 0 and 1 must be 0xAA, byte 16 carries the payload
// length L, and the frame end index E = 17 + L must lie below MAX_FRAME - 17.
// Bytes 17 to E-1 come out as payload with payload_valid set; bytes E and E+1
// must be 0xBB, and byte E+2 must equal the reflected CRC-8 (polynomial 0x8C,
// initial value zero) over bytes 0 to E+1. The byte that ends checking carries
// frame_done with a status of ok, format error or CRC mismatch. After a frame
// has ended, bytes without restart produce an all-zero result until the next
// restart; a restart in the middle of a frame drops it without a done result.
// The block takes one byte every clock while the result register has room;
// its result is available in the cycle after acceptance. The decision for a
// byte, with an unrolled byte-wide CRC update, is combinational and is held in
// the result register, which may be refilled in the same cycle it is emptied.
// Back-pressure on the result channel holds the byte channel off for as long
// as the result register is full and not being taken.
module crc8_frame_checker
    import crc8fc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    crc8fc_stream_if.sink   byte_ch,
    crc8fc_stream_if.source result_ch
);

    logic      can_load;
    logic      accept;
    out_item_t core_result;

    // A byte is accepted whenever the result register has room for its result.
    assign byte_ch.ready = can_load;
    assign accept        = byte_ch.valid && can_load;

    crc8fc_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_ch.payload),
        .result (core_result)
    );

    crc8fc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_item (core_result),
        .can_load  (can_load),
        .result_ch (result_ch)
    );

endmodule
